// ===== sv/tip_pkg.sv =====
package tip_pkg;

    // Field and datapath widths fixed by the Q16.16 format
    localparam int XW   = 32;            // coordinate, value, slope
    localparam int DW   = XW + 1;        // difference of two Q16.16 numbers
    localparam int FRAC = 16;            // fraction bits
    localparam int QW   = DW + FRAC;     // dividend and quotient of the divider
    localparam int WW   = FRAC + 1;      // weight, unsigned 0..1.0
    localparam int PW   = DW + WW;       // blend product

    localparam int IDX_W  = 8;
    localparam int CFG_W  = 9;
    localparam int IN_W   = 104;         // index, coord, value, x
    localparam int OUT_W  = 64;          // value, slope
    localparam int STAT_W = 2;

    localparam int FETCH_N = 6;          // entries loaded after the search

    localparam logic [WW-1:0] W_ONE = WW'(1) << FRAC;
    localparam logic [XW-1:0] S_MAX = {1'b0, {(XW-1){1'b1}}};
    localparam logic [XW-1:0] S_MIN = {1'b1, {(XW-1){1'b0}}};

    typedef enum logic [1:0] {
        RESP_OK    = 2'd0,
        RESP_WRITE = 2'd1,
        RESP_ERR   = 2'd2
    } t_resp;

    typedef enum logic [3:0] {
        STP_IW,   // interpolation weight
        STP_IB,   // interpolation blend
        STP_S12,  // slope of the center segment
        STP_S01,  // slope of the left segment
        STP_S23,  // slope of the right segment
        STP_W0,   // left node weight
        STP_B0,   // left node slope
        STP_W1,   // right node weight
        STP_B1,   // right node slope
        STP_W2,   // position weight
        STP_B2,   // final slope blend
        STP_END
    } t_step;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_PICK,
        ST_FETCH,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_BLD_MUL,
        ST_BLD_ADD,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic  accept;
        logic  write;
        logic  walk_go;
        logic  walk_run;
        logic  pick;
        logic  fetch_go;
        logic  fetch_run;
        logic  div_go;
        logic  div_fin;
        logic  bld_mul;
        logic  bld_add;
        logic  load_out;
        t_step step;
        t_resp code;
    } t_cmd;

    typedef struct packed {
        logic few;
        logic walk_done;
        logic fetch_done;
        logic div_busy;
        logic div_done;
        logic interp_found;
        logic full;
    } t_sts;

    function automatic logic step_is_div(input t_step s);
        return (s == STP_IW) || (s == STP_S12) || (s == STP_S01) || (s == STP_S23) ||
               (s == STP_W0) || (s == STP_W1) || (s == STP_W2);
    endfunction

    function automatic t_step step_next(input t_step s, input logic full);
        t_step r;
        case (s)
            STP_IW:  r = STP_IB;
            STP_IB:  r = STP_S12;
            STP_S12: r = full ? STP_S01 : STP_END;
            STP_S01: r = STP_S23;
            STP_S23: r = STP_W0;
            STP_W0:  r = STP_B0;
            STP_B0:  r = STP_W1;
            STP_W1:  r = STP_B1;
            STP_B1:  r = STP_W2;
            STP_W2:  r = STP_B2;
            default: r = STP_END;
        endcase
        return r;
    endfunction

    function automatic logic [DW-1:0] mag(input logic [DW-1:0] a);
        return a[DW-1] ? (~a + 1'b1) : a;
    endfunction

endpackage

// ===== sv/tip_div.sv =====
module tip_div import tip_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [QW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);

    localparam int CW = $clog2(QW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_dvd;
    logic [DW-1:0] r_dvs;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;

    // restoring division, one quotient bit per cycle
    assign shifted = {r_rem, r_dvd[QW-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign ge      = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
                r_dvd <= {r_dvd[QW-2:0], ge};
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

// ===== sv/tip_ctrl.sv =====
module tip_ctrl import tip_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_kind,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    t_step  r_step, n_step;
    t_resp  r_code, n_code;
    logic   r_ovalid, n_ovalid;
    t_cmd   cmd;

    function automatic t_state dispatch(input t_step s);
        if (s == STP_END) begin
            return ST_FINISH;
        end else if (step_is_div(s)) begin
            return ST_DIV_GO;
        end
        return ST_BLD_MUL;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= STP_END;
            r_code   <= RESP_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_code   <= n_code;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_code   = r_code;
        n_ovalid = r_ovalid;
        cmd      = '0;
        cmd.step = r_step;
        cmd.code = r_code;
        if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    if (!i_in_kind) begin
                        cmd.write = 1'b1;
                        n_code    = RESP_WRITE;
                        n_state   = ST_FINISH;
                    end else if (i_sts.few) begin
                        n_code  = RESP_ERR;
                        n_state = ST_FINISH;
                    end else begin
                        n_code      = RESP_OK;
                        cmd.walk_go = 1'b1;
                        n_state     = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                cmd.walk_run = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                cmd.pick     = 1'b1;
                cmd.fetch_go = 1'b1;
                n_state      = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.fetch_run = 1'b1;
                if (i_sts.fetch_done) begin
                    n_step  = i_sts.interp_found ? STP_IW : STP_S12;
                    n_state = dispatch(n_step);
                end
            end
            ST_DIV_GO: begin
                cmd.div_go = 1'b1;
                n_state    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    cmd.div_fin = 1'b1;
                    n_step      = step_next(r_step, i_sts.full);
                    n_state     = dispatch(n_step);
                end
            end
            ST_BLD_MUL: begin
                cmd.bld_mul = 1'b1;
                n_state     = ST_BLD_ADD;
            end
            ST_BLD_ADD: begin
                cmd.bld_add = 1'b1;
                n_step      = step_next(r_step, i_sts.full);
                n_state     = dispatch(n_step);
            end
            ST_FINISH: begin
                // hold the result until the output register is free
                if (!r_ovalid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_cmd       = cmd;

endmodule

// ===== sv/tip_dp.sv =====
module tip_dp import tip_pkg::*; #(
    parameter int MAX_POINTS = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_W-1:0]        i_cfg_wr_data,
    input  logic [IDX_W-1:0]        i_index,
    input  logic signed [XW-1:0]    i_coord,
    input  logic signed [XW-1:0]    i_value,
    input  logic signed [XW-1:0]    i_x,
    output logic [XW-1:0]           o_value,
    output logic [XW-1:0]           o_slope,
    output t_resp                   o_status
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int DEPTH = 1 << AW;
    localparam int FW    = $clog2(FETCH_N);

    typedef enum logic [1:0] {IM_NONE, IM_CLAMP, IM_FOUND} t_imode;

    // configuration and table
    logic [CFG_W-1:0]   r_piu;
    logic [NW-1:0]      pts;
    logic [AW-1:0]      last_k, pen_k;
    logic [2*XW-1:0]    r_mem [DEPTH];
    logic [2*XW-1:0]    r_rdata;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic               idx_ok;
    logic signed [XW-1:0] rd_c, rd_v;
    logic signed [XW-1:0] r_x;

    // search
    logic [AW-1:0]      r_k, r_dk, r_t, r_i, r_a, r_b;
    logic               r_issue, r_dv;
    logic               r_low, r_high, r_dlow, r_dhigh, r_tf, r_if;
    logic signed [XW-1:0] r_prevc;
    t_imode             r_imode;
    logic               r_full;

    // fetch
    logic [FW-1:0]      r_f, r_fd, f_off, fd_off;
    logic               r_fissue, r_fv;
    logic [AW-1:0]      f_addr;
    logic signed [XW-1:0] r_pc [4];
    logic signed [XW-1:0] r_pv [4];
    logic signed [XW-1:0] r_qc [2];
    logic signed [XW-1:0] r_qv [2];

    // arithmetic
    logic signed [XW-1:0] na, nb, da, db, ba, bb;
    logic [DW-1:0]      num, den, un, ud, bd;
    logic               sgn_diff, sat;
    logic [QW-1:0]      quot;
    logic [XW-1:0]      slope_res;
    logic [WW-1:0]      w_res;
    logic               div_busy, div_done;
    logic [WW-1:0]      r_w;
    logic signed [XW-1:0] r_s01, r_s12, r_s23, r_res, r_ival;
    logic               r_fault;
    logic [PW-1:0]      r_prod;
    logic               r_bneg;
    logic signed [XW-1:0] r_ba;
    logic [DW:0]        bsum;
    logic [XW-1:0]      r_oval, r_oslope;
    t_resp              r_ostat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piu <= CFG_W'(2);
        end else if (i_cfg_wr_en) begin
            r_piu <= i_cfg_wr_data;
        end
    end

    assign pts    = (32'(r_piu) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(r_piu);
    assign last_k = AW'(pts - NW'(1));
    assign pen_k  = AW'(pts - NW'(2));
    assign idx_ok = 32'(i_index) < 32'(MAX_POINTS);
    assign wr_addr = AW'(i_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x <= i_x;
        end
    end

    // table memory, coordinate in the low half
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && idx_ok) begin
            r_mem[wr_addr] <= {i_value, i_coord};
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign rd_c = r_rdata[XW-1:0];
    assign rd_v = r_rdata[2*XW-1:XW];

    assign f_off   = r_f - FW'(2);
    assign fd_off  = r_fd - FW'(2);
    always_comb begin
        case (r_f)
            FW'(0):  f_addr = r_a;
            FW'(1):  f_addr = r_a + 1'b1;
            default: f_addr = r_b + AW'(f_off);
        endcase
    end
    assign rd_addr = i_cmd.fetch_run ? f_addr : r_k;

    // walk the table, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_dv    <= 1'b0;
        end else if (i_cmd.walk_go) begin
            r_issue <= 1'b1;
            r_dv    <= 1'b0;
            r_k     <= '0;
        end else if (i_cmd.walk_run) begin
            r_dv <= r_issue;
            r_dk <= r_k;
            if (r_issue) begin
                if (r_k == last_k) begin
                    r_issue <= 1'b0;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end else begin
            r_issue <= 1'b0;
            r_dv    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_go) begin
            r_low   <= 1'b0;
            r_high  <= 1'b0;
            r_dlow  <= 1'b0;
            r_dhigh <= 1'b0;
            r_tf    <= 1'b0;
            r_if    <= 1'b0;
        end else if (i_cmd.walk_run && r_dv) begin
            if (r_dk == '0) begin
                r_low <= r_x < rd_c;
            end
            if (r_dk == AW'(1)) begin
                r_dlow <= r_x < rd_c;
            end
            if (r_dk == pen_k) begin
                r_dhigh <= r_x > rd_c;
            end
            if (r_dk == last_k) begin
                r_high <= r_x > rd_c;
            end
            // first segment that holds x
            if (r_dk != '0 && !r_tf && r_prevc <= r_x && r_x <= rd_c) begin
                r_tf <= 1'b1;
                r_t  <= r_dk - 1'b1;
            end
            // first inner node at or above x
            if (r_dk != '0 && r_dk <= pen_k && !r_if && r_x <= rd_c) begin
                r_if <= 1'b1;
                r_i  <= r_dk;
            end
            r_prevc <= rd_c;
        end
    end

    // choose the entries to load
    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            if (r_low) begin
                r_imode <= IM_CLAMP;
                r_a     <= '0;
            end else if (r_high) begin
                r_imode <= IM_CLAMP;
                r_a     <= last_k;
            end else if (r_tf) begin
                r_imode <= IM_FOUND;
                r_a     <= r_t;
            end else begin
                r_imode <= IM_NONE;
                r_a     <= '0;
            end
            // end segments sit in loaded points one and two
            if (r_dlow || (!r_dhigh && r_i == AW'(1))) begin
                r_full <= 1'b0;
                r_b    <= '1;
            end else if (r_dhigh) begin
                r_full <= 1'b0;
                r_b    <= pen_k - 1'b1;
            end else begin
                r_full <= 1'b1;
                r_b    <= r_i - AW'(2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fissue <= 1'b0;
            r_fv     <= 1'b0;
        end else if (i_cmd.fetch_go) begin
            r_fissue <= 1'b1;
            r_fv     <= 1'b0;
            r_f      <= '0;
        end else if (i_cmd.fetch_run) begin
            r_fv <= r_fissue;
            r_fd <= r_f;
            if (r_fissue) begin
                if (r_f == FW'(FETCH_N - 1)) begin
                    r_fissue <= 1'b0;
                end else begin
                    r_f <= r_f + 1'b1;
                end
            end
        end else begin
            r_fissue <= 1'b0;
            r_fv     <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fv) begin
            case (r_fd)
                FW'(0): begin
                    r_qc[0] <= rd_c;
                    r_qv[0] <= rd_v;
                end
                FW'(1): begin
                    r_qc[1] <= rd_c;
                    r_qv[1] <= rd_v;
                end
                default: begin
                    r_pc[2'(fd_off)] <= rd_c;
                    r_pv[2'(fd_off)] <= rd_v;
                end
            endcase
        end
    end

    // division operands
    always_comb begin
        case (i_cmd.step)
            STP_IW: begin
                na = r_x;     nb = r_qc[0]; da = r_qc[1]; db = r_qc[0];
            end
            STP_S12: begin
                na = r_pv[2]; nb = r_pv[1]; da = r_pc[2]; db = r_pc[1];
            end
            STP_S01: begin
                na = r_pv[1]; nb = r_pv[0]; da = r_pc[1]; db = r_pc[0];
            end
            STP_S23: begin
                na = r_pv[3]; nb = r_pv[2]; da = r_pc[3]; db = r_pc[2];
            end
            STP_W0: begin
                na = r_pc[1]; nb = r_pc[0]; da = r_pc[2]; db = r_pc[0];
            end
            STP_W1: begin
                na = r_pc[2]; nb = r_pc[1]; da = r_pc[3]; db = r_pc[1];
            end
            default: begin
                na = r_x;     nb = r_pc[1]; da = r_pc[2]; db = r_pc[1];
            end
        endcase
    end

    assign num      = {na[XW-1], na} - {nb[XW-1], nb};
    assign den      = {da[XW-1], da} - {db[XW-1], db};
    assign un       = mag(num);
    assign ud       = mag(den);
    assign sgn_diff = num[DW-1] ^ den[DW-1];

    tip_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend ({un, {FRAC{1'b0}}}),
        .i_divisor  (ud),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign sat       = |quot[QW-1:XW-1];
    assign slope_res = sgn_diff ? (sat ? S_MIN : (~quot[XW-1:0] + 1'b1))
                                : (sat ? S_MAX : quot[XW-1:0]);
    assign w_res     = (num == '0 || sgn_diff) ? '0 :
                       (un >= ud) ? W_ONE : quot[WW-1:0];

    // blend operands
    always_comb begin
        case (i_cmd.step)
            STP_IB: begin
                ba = r_qv[0]; bb = r_qv[1];
            end
            STP_B0: begin
                ba = r_s01;   bb = r_s12;
            end
            STP_B1: begin
                ba = r_s12;   bb = r_s23;
            end
            default: begin
                ba = r_s01;   bb = r_s23;
            end
        endcase
    end

    // the scaled difference never exceeds 2^32, so 33 bits of it are enough
    assign bd   = {bb[XW-1], bb} - {ba[XW-1], ba};
    assign bsum = r_bneg ? ({{2{r_ba[XW-1]}}, r_ba} - {1'b0, r_prod[PW-2:FRAC]})
                         : ({{2{r_ba[XW-1]}}, r_ba} + {1'b0, r_prod[PW-2:FRAC]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= 1'b0;
        end else if (i_cmd.walk_go) begin
            r_fault <= 1'b0;
        end else if (i_cmd.div_go && den == '0) begin
            r_fault <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_fin) begin
            case (i_cmd.step)
                STP_S12: r_s12 <= slope_res;
                STP_S01: r_s01 <= slope_res;
                STP_S23: r_s23 <= slope_res;
                default: r_w   <= w_res;
            endcase
        end
        if (i_cmd.bld_mul) begin
            r_prod <= PW'(mag(bd)) * PW'(r_w);
            r_bneg <= bd[DW-1];
            r_ba   <= ba;
        end
        if (i_cmd.bld_add) begin
            case (i_cmd.step)
                STP_IB:  r_ival <= bsum[XW-1:0];
                STP_B0:  r_s01  <= bsum[XW-1:0];
                STP_B1:  r_s23  <= bsum[XW-1:0];
                default: r_res  <= bsum[XW-1:0];
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (i_cmd.code == RESP_OK && !r_fault) begin
                case (r_imode)
                    IM_CLAMP: r_oval <= r_qv[0];
                    IM_FOUND: r_oval <= r_ival;
                    default:  r_oval <= '0;
                endcase
                r_oslope <= r_full ? r_res : r_s12;
                r_ostat  <= RESP_OK;
            end else begin
                r_oval   <= '0;
                r_oslope <= '0;
                r_ostat  <= (i_cmd.code == RESP_OK) ? RESP_ERR : i_cmd.code;
            end
        end
    end

    assign o_value  = r_oval;
    assign o_slope  = r_oslope;
    assign o_status = r_ostat;

    assign o_sts.few          = pts < NW'(3);
    assign o_sts.walk_done    = r_dv && (r_dk == last_k);
    assign o_sts.fetch_done   = r_fv && (r_fd == FW'(FETCH_N - 1));
    assign o_sts.div_busy     = div_busy;
    assign o_sts.div_done     = div_done;
    assign o_sts.interp_found = (r_imode == IM_FOUND);
    assign o_sts.full         = r_full;

endmodule

// ===== sv/table_interpolator_with_slope_top.sv =====
// Piecewise-linear table interpolator with a slope estimate, signed Q16.16 throughout.
// A transfer with tuser 0 writes one table slot (coordinate and value) and is answered
// with status 1 once the finish state has loaded the output register; a transfer with
// tuser 1 queries at position x and returns the interpolated value (clamped to the end
// values outside the table, zero where no segment holds x) and a saturated slope that
// blends node slopes inside the table and uses the end segment slope near either end.
// Status 2 flags fewer than three points in use or a zero-width segment, with zero
// payload. One item is in work at a time. A query walks the table and loads six entries
// through the single read port of the table memory, then runs each division on the
// shared radix-2 divider (1 to 7 of them) and each blend (0 to 4), and last loads the
// output. The table holds MAX_POINTS entries and needs no clearing after reset; the user
// must write points_in_use through the configuration port only while the block is idle,
// and the block itself does not enforce this.
module table_interpolator_with_slope_top import tip_pkg::*; #(
    parameter int MAX_POINTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CFG_W-1:0]    i_cfg_wr_data,  // points_in_use
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [IN_W-1:0]     s_axis_tdata,   // entry_index, entry_coord, entry_value, query_x
    input  logic [0:0]          s_axis_tuser,   // kind
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata,   // interp_value, slope
    output logic [STAT_W-1:0]   m_axis_tuser    // status
);

    t_cmd          cmd;
    t_sts          sts;
    logic [XW-1:0] out_value;
    logic [XW-1:0] out_slope;
    t_resp         out_status;

    tip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_kind   (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tip_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_index       (s_axis_tdata[IDX_W-1:0]),
        .i_coord       (s_axis_tdata[IDX_W+XW-1:IDX_W]),
        .i_value       (s_axis_tdata[IDX_W+2*XW-1:IDX_W+XW]),
        .i_x           (s_axis_tdata[IDX_W+3*XW-1:IDX_W+2*XW]),
        .o_value       (out_value),
        .o_slope       (out_slope),
        .o_status      (out_status)
    );

    assign m_axis_tdata = {out_slope, out_value};
    assign m_axis_tuser = out_status;

    // never restart the divider while it is still iterating
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_go |-> !sts.div_busy)
        else $error("divider started while busy");

    // a table write is answered through the finish state and the output register when the output is free
    a_write_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] && !m_axis_tvalid)
        |=> ##1 (m_axis_tvalid && m_axis_tuser == RESP_WRITE))
        else $error("write not acknowledged");

    // error results carry zero payload
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == RESP_ERR) |-> (m_axis_tdata == '0))
        else $error("error result with payload");

endmodule

// ===== dv/tb_table_interpolator_with_slope_top.sv =====
module tb_table_interpolator_with_slope_top;
    import tip_pkg::*;

    localparam int  NPTS       = 256;
    localparam int  CYCLE_CAP  = 4000000;
    localparam int  ITEM_GOAL  = 750;
    localparam longint Q_ONE   = 65536;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] val;
        logic [31:0] slp;
        t_resp       st;
    } t_answer;

    typedef enum int {ROW_CFG, ROW_WR, ROW_QRY} t_row_kind;

    typedef struct {
        t_row_kind rk;
        int        idx;
        longint    crd;     // coordinate, or register value for ROW_CFG
        longint    val;
        longint    x;
        bit        typed;
        t_answer   ans;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [CFG_W-1:0]   i_cfg_wr_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;   // entry_index, entry_coord, entry_value, query_x
    logic [0:0]         s_axis_tuser;   // kind
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;   // interp_value, slope
    logic [STAT_W-1:0]  m_axis_tuser;   // status

    table_interpolator_with_slope_top #(.MAX_POINTS(NPTS)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the table and the point count
    logic signed [31:0] coord_tab [NPTS];
    logic signed [31:0] level_tab [NPTS];
    logic [CFG_W-1:0]   points_cfg;
    bit                 zero_div;

    t_answer answer_q[$];
    int      mism_cnt, items_sent, n_writes, n_queries, n_ok, n_err, n_cfg;
    bit      quiet;
    int      cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic longint absl(longint a);
        return a < 0 ? -a : a;
    endfunction

    function automatic longint crd(int k);
        return longint'(coord_tab[k]);
    endfunction

    function automatic longint lvl(int k);
        return longint'(level_tab[k]);
    endfunction

    // Unsigned Q16.16 fraction num/den clamped to [0, 1.0]
    function automatic longint frac_of(longint num, longint den);
        if (den == 0) begin
            zero_div = 1'b1;
            return 0;
        end
        if (num == 0 || ((num < 0) != (den < 0)))
            return 0;
        if (absl(num) >= absl(den))
            return Q_ONE;
        return (absl(num) <<< 16) / absl(den);
    endfunction

    function automatic longint rise_over_run(int j, int k);
        longint dv, dc, q;
        dv = lvl(k) - lvl(j);
        dc = crd(k) - crd(j);
        if (dc == 0) begin
            zero_div = 1'b1;
            return 0;
        end
        q = (absl(dv) <<< 16) / absl(dc);
        if ((dv < 0) != (dc < 0))
            return (q >= -S32_MIN) ? S32_MIN : -q;
        return (q > S32_MAX) ? S32_MAX : q;
    endfunction

    function automatic longint mix(longint a, longint b, longint f);
        longint d, m;
        d = b - a;
        m = (absl(d) * f) >>> 16;
        return d < 0 ? a - m : a + m;
    endfunction

    function automatic longint value_at(longint x, int n);
        if (x < crd(0))
            return lvl(0);
        if (x > crd(n - 1))
            return lvl(n - 1);
        for (int t = 0; t + 1 < n; t++)
            if (x >= crd(t) && x <= crd(t + 1))
                return mix(lvl(t), lvl(t + 1), frac_of(x - crd(t), crd(t + 1) - crd(t)));
        return 0;
    endfunction

    function automatic longint slope_at(longint x, int n);
        int     i;
        longint d0, d1;
        if (x < crd(1))
            return rise_over_run(0, 1);
        if (x > crd(n - 2))
            return rise_over_run(n - 2, n - 1);
        for (i = 1; i + 1 < n; i++)
            if (x <= crd(i))
                break;
        if (i < 2)
            return rise_over_run(i - 1, i);
        d0 = mix(rise_over_run(i - 2, i - 1), rise_over_run(i - 1, i),
                 frac_of(crd(i - 1) - crd(i - 2), crd(i) - crd(i - 2)));
        d1 = mix(rise_over_run(i - 1, i), rise_over_run(i, i + 1),
                 frac_of(crd(i) - crd(i - 1), crd(i + 1) - crd(i - 1)));
        return mix(d0, d1, frac_of(x - crd(i - 1), crd(i) - crd(i - 1)));
    endfunction

    // Apply one accepted item to the shadow table and return its answer
    function automatic t_answer table_answer(bit kind, int idx, longint c, longint v, longint x);
        t_answer a;
        int      n;
        longint  iv, sv;
        a = '{val: '0, slp: '0, st: RESP_ERR};
        if (!kind) begin
            coord_tab[idx] = c[31:0];
            level_tab[idx] = v[31:0];
            a.st = RESP_WRITE;
            return a;
        end
        n = (points_cfg > NPTS) ? NPTS : points_cfg;
        if (n < 3)
            return a;
        zero_div = 1'b0;
        iv = value_at(x, n);
        sv = slope_at(x, n);
        if (zero_div)
            return a;
        a.val = iv[31:0];
        a.slp = sv[31:0];
        a.st  = RESP_OK;
        return a;
    endfunction

    // ---------------- sender ----------------
    task automatic push_item(bit kind, int idx, longint c, longint v, longint x,
                             bit typed, t_answer ta);
        int      gap;
        t_answer a;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            @(negedge i_clk) s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {x[31:0], v[31:0], c[31:0], 8'(idx)};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        // predict from the 32-bit position the block actually sees
        a = table_answer(kind, idx, c, v, longint'($signed(x[31:0])));
        answer_q.push_back(typed ? ta : a);
        items_sent++;
        if (kind) n_queries++;
        else      n_writes++;
    endtask

    // Hold the sender until every answer is back
    task automatic wait_drained();
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_points(int cnt);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= CFG_W'(cnt);
        @(negedge i_clk) i_cfg_wr_en <= 1'b0;
        points_cfg = CFG_W'(cnt);
        n_cfg++;
    endtask

    // Write slots 0..n-1 with an ascending table of random content
    task automatic load_table(int n, longint step_cap);
        longint c, st, v;
        c = S32_MIN + $urandom_range(0, 1 << 20);
        if (step_cap > (64'd3 << 30) / n) step_cap = (64'd3 << 30) / n;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 3))
                0:       v = longint'($signed($urandom()));
                1:       v = $urandom_range(0, 1) ? S32_MAX : S32_MIN;
                default: v = longint'($signed(32'($urandom_range(0, 1 << 22)))) - (1 << 21);
            endcase
            push_item(1'b0, k, c, v, 0, 1'b0, '0);
            st = 1 + longint'($urandom()) % step_cap;
            c  = c + st;
        end
    endtask

    function automatic longint pick_x(int n);
        int k;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return crd(k) + $signed($urandom_range(0, 4)) - 2;
            4, 5, 6:    return (k + 1 < n) ? crd(k) + longint'($urandom()) %
                               (absl(crd(k + 1) - crd(k)) + 1) : crd(k);
            7:          return longint'($signed($urandom()));
            8:          return S32_MIN;
            default:    return S32_MAX;
        endcase
    endfunction

    // A mixed burst: mostly queries, some table edits, an occasional drain
    task automatic random_burst(int n, int cnt);
        int     k;
        longint c;
        for (int j = 0; j < cnt; j++) begin
            k = $urandom_range(0, NPTS - 1);
            case ($urandom_range(0, 19))
                0:  push_item(1'b0, k, longint'($signed($urandom())),
                              longint'($signed($urandom())), longint'($signed($urandom())),
                              1'b0, '0);
                1: begin
                    // duplicate a neighbor's coordinate for a zero-width segment
                    k = $urandom_range(0, n - 2);
                    push_item(1'b0, k, crd(k + 1), longint'($signed($urandom())), 0, 1'b0, '0);
                end
                2:  push_item(1'b0, k, crd(k), longint'($signed($urandom())), 0, 1'b0, '0);
                3:  if ($urandom_range(0, 3) == 0) wait_drained();
                default: push_item(1'b1, 0, 0, 0, pick_x(n), 1'b0, '0);
            endcase
        end
    endtask

    // ---------------- receiver ----------------
    initial begin
        int k;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            k = quiet ? 0 : $urandom_range(0, 11);
            if (k > 0) begin
                @(negedge i_clk) m_axis_tready <= 1'b0;
                repeat (k - 1) @(negedge i_clk);
            end
            @(negedge i_clk) m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Compare each transfer with the oldest answer waiting
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answer_q.size() == 0) begin
                mism_cnt++;
                if (mism_cnt <= 10)
                    $display("unexpected result: data %h status %0d", m_axis_tdata, m_axis_tuser);
            end else begin
                a = answer_q.pop_front();
                if (m_axis_tdata[31:0] !== a.val || m_axis_tdata[63:32] !== a.slp ||
                    m_axis_tuser !== a.st) begin
                    mism_cnt++;
                    if (mism_cnt <= 10)
                        $display("mismatch: exp value %h slope %h status %0d, got %h %h %0d",
                                 a.val, a.slp, a.st, m_axis_tdata[31:0],
                                 m_axis_tdata[63:32], m_axis_tuser);
                end
                if (a.st == RESP_OK)  n_ok++;
                if (a.st == RESP_ERR) n_err++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tb_table_interpolator_with_slope_top: errors");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        t_row    rows[$];
        t_answer wr_ack, err_ans;
        int      n;
        wr_ack  = '{val: '0, slp: '0, st: RESP_WRITE};
        err_ans = '{val: '0, slp: '0, st: RESP_ERR};
        cycles = 0;
        quiet  = 1'b0;
        points_cfg = CFG_W'(2);
        for (int k = 0; k < NPTS; k++) begin
            coord_tab[k] = '0;
            level_tab[k] = '0;
        end
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: two points after reset are too few, then extremes of coords and values
        rows.push_back('{ROW_QRY, 0, 0, 0, 0, 1, err_ans});
        rows.push_back('{ROW_WR, 0, S32_MIN, S32_MAX, 0, 1, wr_ack});
        rows.push_back('{ROW_WR, 1, -65536, S32_MIN, 0, 1, wr_ack});
        rows.push_back('{ROW_WR, 2, 0, 0, 0, 1, wr_ack});
        rows.push_back('{ROW_WR, 3, 65536, 65536, 0, 1, wr_ack});
        rows.push_back('{ROW_WR, 4, S32_MAX, S32_MIN, 0, 1, wr_ack});
        rows.push_back('{ROW_WR, 255, S32_MAX, S32_MAX, S32_MAX, 1, wr_ack});
        rows.push_back('{ROW_QRY, 0, 0, 0, 65536, 1, err_ans});
        rows.push_back('{ROW_CFG, 0, 5, 0, 0, 0, '0});
        rows.push_back('{ROW_QRY, 0, 0, 0, S32_MIN, 0, '0});
        rows.push_back('{ROW_QRY, 0, 0, 0, S32_MAX, 0, '0});
        rows.push_back('{ROW_QRY, 0, 0, 0, 0, 0, '0});
        rows.push_back('{ROW_QRY, 0, 0, 0, 32768, 0, '0});
        rows.push_back('{ROW_QRY, 0, 0, 0, -100000, 0, '0});
        rows.push_back('{ROW_QRY, 0, 0, 0, -65536, 0, '0});
        // zero-width segment
        rows.push_back('{ROW_WR, 3, 0, 7, 0, 1, wr_ack});
        rows.push_back('{ROW_QRY, 0, 0, 0, 16, 0, '0});
        // out of order table: some positions have no enclosing segment
        rows.push_back('{ROW_WR, 3, -1 << 30, 7, 0, 1, wr_ack});
        rows.push_back('{ROW_WR, 1, 1 << 30, 9, 0, 1, wr_ack});
        rows.push_back('{ROW_QRY, 0, 0, 0, 1 << 29, 0, '0});
        rows.push_back('{ROW_QRY, 0, 0, 0, -(1 << 29), 0, '0});
        rows.push_back('{ROW_CFG, 0, 0, 0, 0, 0, '0});
        rows.push_back('{ROW_QRY, 0, 0, 0, 5, 1, err_ans});

        foreach (rows[r]) begin
            case (rows[r].rk)
                ROW_CFG: set_points(int'(rows[r].crd));
                ROW_WR:  push_item(1'b0, rows[r].idx, rows[r].crd, rows[r].val, rows[r].x,
                                   rows[r].typed, rows[r].ans);
                default: push_item(1'b1, 0, 0, 0, rows[r].x, rows[r].typed, rows[r].ans);
            endcase
        end

        // Full table, then the saturating register value, with no idling for a stretch
        load_table(NPTS, 64'd1 << 23);
        set_points(NPTS);
        quiet = 1'b1;
        random_burst(NPTS, 60);
        quiet = 1'b0;
        random_burst(NPTS, 60);
        set_points(511);
        random_burst(NPTS, 30);
        set_points(1);
        push_item(1'b1, 0, 0, 0, 0, 1'b1, err_ans);

        // Small tables with fresh content until the item budget is spent
        while (items_sent < ITEM_GOAL) begin
            n = ($urandom_range(0, 2) == 0) ? 3 : $urandom_range(3, 12);
            set_points(2);
            case ($urandom_range(0, 2))
                0:       load_table(n, 16);
                1:       load_table(n, 1 << 16);
                default: load_table(n, 64'd1 << 31);
            endcase
            set_points(n);
            quiet = ($urandom_range(0, 4) == 0);
            random_burst(n, 40);
            quiet = 1'b0;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("run covered %0d writes and %0d queries over %0d register settings",
                 n_writes, n_queries, n_cfg);
        $display("answers: %0d ok, %0d error status, %0d mismatches", n_ok, n_err, mism_cnt);
        if (mism_cnt == 0 && answer_q.size() == 0)
            $display("tb_table_interpolator_with_slope_top: clean");
        else
            $display("tb_table_interpolator_with_slope_top: errors");
        $finish;
    end

endmodule

// ===== table_interpolator_with_slope_top.f =====
sv/tip_pkg.sv
sv/tip_div.sv
sv/tip_ctrl.sv
sv/tip_dp.sv
sv/table_interpolator_with_slope_top.sv
dv/tb_table_interpolator_with_slope_top.sv
